[hdl/blda_pkg.sv]
// Shared types and constants of the bonded link distributor.
// Used by every module of the block but blda_ram; depends on nothing.
package blda_pkg;

	localparam int unsigned LEN_W       = 32;  // message and piece lengths
	localparam int unsigned BYTES_W     = 64;  // per-link byte counters
	localparam int unsigned LINK_W      = 3;   // link index
	localparam int unsigned NUM_W       = 4;   // link counts
	localparam int unsigned MODE_W      = 2;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned CFG_DATA_W  = 32;
	localparam int unsigned RESULT_CAP  = 8;   // most pieces one message can make
	localparam int unsigned MAX_LINKS_DEF = 8;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [LEN_W-1:0] THR_RESET        = LEN_W'(64 * 1024);
	localparam logic [NUM_W-1:0] LINK_COUNT_RESET = NUM_W'(1);

	// Divider: 8 quotient bits per cycle
	localparam int unsigned DIV_STEPS  = 8;
	localparam int unsigned DIV_ROUNDS = LEN_W / DIV_STEPS;
	localparam int unsigned DIV_CNT_W  = (DIV_ROUNDS > 1) ? $clog2(DIV_ROUNDS) : 1;

	typedef enum logic [MODE_W-1:0] {
		MODE_RR     = 2'd0,
		MODE_LL     = 2'd1,
		MODE_BCAST  = 2'd2,
		MODE_STRIPE = 2'd3
	} bond_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BOND_MODE  = 2'd0,
		CFG_LINK_COUNT = 2'd1,
		CFG_STRIPE_THR = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CMD_SINGLE = 2'd0,  // whole message on a link chosen up front
		CMD_LEAST  = 2'd1,  // whole message on the least loaded link
		CMD_BCAST  = 2'd2,  // whole message on every link
		CMD_STRIPE = 2'd3   // message split across every link
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [LEN_W-1:0]  len;
		logic [NUM_W-1:0]  n;
		logic [LINK_W-1:0] link;
	} cmd_t;

	typedef struct packed {
		logic [LINK_W-1:0]  link;
		logic [LEN_W-1:0]   piece_len;
		logic               is_stripe;
		logic [LINK_W-1:0]  stripe_index;
		logic [NUM_W-1:0]   stripe_total;
		logic [BYTES_W-1:0] link_bytes;
		logic               last;
	} result_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_DIV  = 2'd1,
		BK_SCAN = 2'd2,
		BK_EMIT = 2'd3
	} back_state_t;

endpackage

[hdl/blda_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module blda_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 8,
	parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hdl/blda_queue.sv]
// Short command queue between the front and the back of the distributor.
// Depends on blda_pkg for the command type.
module blda_queue
	import blda_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic empty,
	output cmd_t pop_cmd
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	cmd_t             ent_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign pop_cmd = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

[hdl/blda_front.sv]
// Front of the distributor: configuration registers, message intake,
// classification and the round-robin pointer. Depends on blda_pkg.
module blda_front
	import blda_pkg::*;
#(
	parameter int unsigned LINK_CAP = MAX_LINKS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [LEN_W-1:0]      msg_len,
	input  logic                  q_full,
	output logic                  push,
	output cmd_t                  push_cmd
);

	localparam logic [NUM_W-1:0] CAP_N = NUM_W'(LINK_CAP);

	bond_mode_t        bond_mode_q;
	logic [NUM_W-1:0]  link_count_q;
	logic [LEN_W-1:0]  thr_q;
	logic [LINK_W-1:0] rr_ptr_q;

	logic [NUM_W-1:0]  eff_n;
	logic [LINK_W-1:0] rr_link;
	logic [NUM_W-1:0]  rr_next;
	logic              take_rr;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	always_comb begin
		// clamp the link count to the usable range
		if (link_count_q == '0) begin
			eff_n = NUM_W'(1);
		end else if (link_count_q > CAP_N) begin
			eff_n = CAP_N;
		end else begin
			eff_n = link_count_q;
		end

		// a stale pointer falls back to link 0
		rr_link = ({1'b0, rr_ptr_q} < eff_n) ? rr_ptr_q : '0;
		rr_next = {1'b0, rr_link} + NUM_W'(1);
		if (rr_next >= eff_n) begin
			rr_next = '0;
		end

		push_cmd.len  = msg_len;
		push_cmd.n    = eff_n;
		push_cmd.link = rr_link;
		take_rr       = 1'b0;
		case (bond_mode_q)
			MODE_BCAST: begin
				push_cmd.kind = CMD_BCAST;
			end
			MODE_LL: begin
				push_cmd.kind = CMD_LEAST;
			end
			MODE_STRIPE: begin
				if (msg_len > thr_q && eff_n > NUM_W'(1)) begin
					push_cmd.kind = CMD_STRIPE;
				end else begin
					push_cmd.kind = CMD_SINGLE;
					take_rr       = 1'b1;
				end
			end
			default: begin
				push_cmd.kind = CMD_SINGLE;
				take_rr       = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bond_mode_q  <= MODE_RR;
			link_count_q <= LINK_COUNT_RESET;
			thr_q        <= THR_RESET;
			rr_ptr_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_BOND_MODE:  bond_mode_q  <= bond_mode_t'(cfg_data[MODE_W-1:0]);
					CFG_LINK_COUNT: link_count_q <= cfg_data[NUM_W-1:0];
					CFG_STRIPE_THR: thr_q        <= cfg_data[LEN_W-1:0];
					default: ;
				endcase
			end
			if (push && take_rr) begin
				rr_ptr_q <= rr_next[LINK_W-1:0];
			end
		end
	end

endmodule

[hdl/blda_back.sv]
// Back of the distributor: stripe divider, least-loaded scan, counter
// update and result register. Depends on blda_pkg and blda_ram.
module blda_back
	import blda_pkg::*;
#(
	parameter int unsigned LINK_CAP = MAX_LINKS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_empty,
	output logic    q_pop,
	input  cmd_t    q_cmd,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t res
);

	localparam int unsigned ADDR_W = (LINK_CAP > 1) ? $clog2(LINK_CAP) : 1;

	back_state_t        state_q, state_d;
	cmd_t               cmd_q, cmd_d;
	logic [LINK_W-1:0]  idx_q, idx_d;
	logic               rd_ok_q, rd_ok_d;
	logic               rdv_q;
	logic [LINK_CAP-1:0] valid_q;
	logic [NUM_W-1:0]   scan_cnt_q, scan_cnt_d;
	logic               got_q, got_d;
	logic [BYTES_W-1:0] best_q, best_d;
	logic [LINK_W-1:0]  best_idx_q, best_idx_d;
	logic [LINK_W-1:0]  sel_link_q, sel_link_d;
	logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;
	logic [LEN_W-1:0]   w_q, w_d;
	logic [NUM_W-1:0]   r_q, r_d;
	logic               out_valid_q;
	result_t            res_q, res_d;
	logic               out_load;

	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [BYTES_W-1:0] ram_wdata;
	logic               ram_re;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [BYTES_W-1:0] ram_rdata;

	logic [BYTES_W-1:0] cur_cnt;
	logic [BYTES_W-1:0] new_cnt;
	logic               multi;
	logic               is_str;
	logic [LINK_W-1:0]  emit_link;
	logic [LINK_W-1:0]  idx_inc;
	logic               last_piece;
	logic [LEN_W-1:0]   piece;
	logic               out_free;
	logic [LINK_W-1:0]  proc_idx;
	logic               take;
	logic [BYTES_W-1:0] best_nx;
	logic [LINK_W-1:0]  best_idx_nx;
	logic [LEN_W-1:0]   div_w;
	logic [NUM_W-1:0]   div_r;

	blda_ram #(
		.WIDTH (BYTES_W),
		.DEPTH (LINK_CAP)
	) u_cnt_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign out_valid = out_valid_q;
	assign res       = res_q;

	// counter of a never-written link reads as zero
	assign cur_cnt    = rdv_q ? ram_rdata : '0;
	assign multi      = (cmd_q.kind == CMD_BCAST) || (cmd_q.kind == CMD_STRIPE);
	assign is_str     = (cmd_q.kind == CMD_STRIPE);
	assign emit_link  = multi ? idx_q : sel_link_q;
	assign idx_inc    = idx_q + LINK_W'(1);
	assign last_piece = !multi || ({1'b0, idx_q} == cmd_q.n - NUM_W'(1));
	// last stripe takes the remainder: len - part*(n-1) = part + rem
	assign piece      = is_str ? (last_piece ? w_q + LEN_W'(r_q) : w_q) : cmd_q.len;
	assign new_cnt    = cur_cnt + BYTES_W'(piece);
	assign out_free   = !out_valid_q || out_ready;

	// scan compare: strict less-than keeps the lowest index on a tie
	assign proc_idx    = LINK_W'(scan_cnt_q - NUM_W'(1));
	assign take        = got_q && ((proc_idx == '0) || (cur_cnt < best_q));
	assign best_nx     = take ? cur_cnt : best_q;
	assign best_idx_nx = take ? proc_idx : best_idx_q;

	// restoring divide by the link count, DIV_STEPS quotient bits per cycle
	always_comb begin
		logic [NUM_W:0] t;
		logic           qbit;
		div_w = w_q;
		div_r = r_q;
		for (int k = 0; k < DIV_STEPS; k++) begin
			t = {div_r, div_w[LEN_W-1]};
			if (t >= {1'b0, cmd_q.n}) begin
				t    = t - {1'b0, cmd_q.n};
				qbit = 1'b1;
			end else begin
				qbit = 1'b0;
			end
			div_r = t[NUM_W-1:0];
			div_w = {div_w[LEN_W-2:0], qbit};
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd_d      = cmd_q;
		idx_d      = idx_q;
		rd_ok_d    = rd_ok_q;
		scan_cnt_d = scan_cnt_q;
		got_d      = got_q;
		best_d     = best_q;
		best_idx_d = best_idx_q;
		sel_link_d = sel_link_q;
		div_cnt_d  = div_cnt_q;
		w_d        = w_q;
		r_d        = r_q;
		q_pop      = 1'b0;
		out_load   = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = emit_link[ADDR_W-1:0];
		ram_wdata  = new_cnt;
		ram_re     = 1'b0;
		ram_raddr  = emit_link[ADDR_W-1:0];

		res_d.link         = emit_link;
		res_d.piece_len    = piece;
		res_d.is_stripe    = is_str;
		res_d.stripe_index = is_str ? idx_q : '0;
		res_d.stripe_total = is_str ? cmd_q.n : '0;
		res_d.link_bytes   = new_cnt;
		res_d.last         = last_piece;

		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop      = 1'b1;
					cmd_d      = q_cmd;
					idx_d      = '0;
					rd_ok_d    = 1'b0;
					sel_link_d = q_cmd.link;
					case (q_cmd.kind)
						CMD_STRIPE: begin
							state_d   = BK_DIV;
							w_d       = q_cmd.len;
							r_d       = '0;
							div_cnt_d = '0;
						end
						CMD_LEAST: begin
							state_d    = BK_SCAN;
							scan_cnt_d = '0;
							got_d      = 1'b0;
						end
						default: begin
							state_d = BK_EMIT;
						end
					endcase
				end
			end
			BK_DIV: begin
				w_d       = div_w;
				r_d       = div_r;
				div_cnt_d = div_cnt_q + DIV_CNT_W'(1);
				if (div_cnt_q == DIV_CNT_W'(DIV_ROUNDS - 1)) begin
					state_d = BK_EMIT;
				end
			end
			BK_SCAN: begin
				best_d     = best_nx;
				best_idx_d = best_idx_nx;
				if (scan_cnt_q < cmd_q.n) begin
					ram_re     = 1'b1;
					ram_raddr  = scan_cnt_q[ADDR_W-1:0];
					scan_cnt_d = scan_cnt_q + NUM_W'(1);
					got_d      = 1'b1;
				end else begin
					got_d      = 1'b0;
					sel_link_d = best_idx_nx;
					state_d    = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (!rd_ok_q) begin
					ram_re  = 1'b1;
					rd_ok_d = 1'b1;
				end else if (out_free) begin
					ram_we   = 1'b1;
					out_load = 1'b1;
					if (last_piece) begin
						rd_ok_d = 1'b0;
						state_d = BK_IDLE;
					end else begin
						// fetch the next link's counter while this beat goes out
						idx_d     = idx_inc;
						ram_re    = 1'b1;
						ram_raddr = idx_inc[ADDR_W-1:0];
					end
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			rd_ok_q     <= 1'b0;
			got_q       <= 1'b0;
			valid_q     <= '0;
			rdv_q       <= 1'b0;
			out_valid_q <= 1'b0;
			scan_cnt_q  <= '0;
			idx_q       <= '0;
			div_cnt_q   <= '0;
		end else begin
			state_q    <= state_d;
			rd_ok_q    <= rd_ok_d;
			got_q      <= got_d;
			scan_cnt_q <= scan_cnt_d;
			idx_q      <= idx_d;
			div_cnt_q  <= div_cnt_d;
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			if (ram_re) begin
				rdv_q <= valid_q[ram_raddr];
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_q      <= cmd_d;
		best_q     <= best_d;
		best_idx_q <= best_idx_d;
		sel_link_q <= sel_link_d;
		w_q        <= w_d;
		r_q        <= r_d;
		if (out_load) begin
			res_q <= res_d;
		end
	end

endmodule

[hdl/bonded_link_distributor.sv]
// Top level of the bonded link distributor: front, command queue and back.
// Depends on blda_pkg, blda_front, blda_queue, blda_back and blda_ram.
//
//  channel   signals                             direction  beat taken when
//  --------  ----------------------------------  ---------  --------------------
//  config    cfg_we, cfg_index, cfg_data         in         cfg_we high
//  message   in_valid/in_ready, msg_len          in         in_valid & in_ready
//  piece     out_valid/out_ready, link .. last   out        out_valid & out_ready
//
// Steps: the back pulls a command from the queue, reads the first link
// counter, then drives the output beats (one beat for round-robin and
// least-loaded, one per active link for broadcast and stripe).
// Least-loaded first scans the link counters; striped first runs the divider.
// The counter RAM has a single read port: one counter read a cycle.
// Reset restores the register defaults, zeroes the round-robin pointer, marks
// every link counter as zero through valid bits and empties the queue.
// out_ready low stalls only the back; the front keeps taking messages until
// the two-entry queue fills.
module bonded_link_distributor
	import blda_pkg::*;
#(
	parameter int unsigned MAX_LINKS = MAX_LINKS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [LEN_W-1:0]      msg_len,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [LINK_W-1:0]     link,
	output logic [LEN_W-1:0]      piece_len,
	output logic                  is_stripe,
	output logic [LINK_W-1:0]     stripe_index,
	output logic [NUM_W-1:0]      stripe_total,
	output logic [BYTES_W-1:0]    link_bytes,
	output logic                  last
);

	// links actually usable: no message makes more pieces than RESULT_CAP
	localparam int unsigned LINK_CAP = (MAX_LINKS < RESULT_CAP) ? MAX_LINKS : RESULT_CAP;

	logic    push;
	cmd_t    push_cmd;
	logic    q_full;
	logic    q_empty;
	logic    q_pop;
	cmd_t    q_cmd;
	result_t res;

	// Front: hold config, classify each message, advance the pointer
	blda_front #(
		.LINK_CAP (LINK_CAP)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.msg_len   (msg_len),
		.q_full    (q_full),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	// Decouple intake from piece generation
	blda_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.pop_cmd  (q_cmd)
	);

	// Back: split, scan, update counters and drive result beats
	blda_back #(
		.LINK_CAP (LINK_CAP)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.q_cmd     (q_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign link         = res.link;
	assign piece_len    = res.piece_len;
	assign is_stripe    = res.is_stripe;
	assign stripe_index = res.stripe_index;
	assign stripe_total = res.stripe_total;
	assign link_bytes   = res.link_bytes;
	assign last         = res.last;

	// A stripe number always lies inside its message
	a_stripe_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_stripe |-> ({1'b0, stripe_index} < stripe_total))
		else $error("stripe index not below stripe total");

	// Striping needs at least two links
	a_stripe_total_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_stripe |-> (stripe_total > NUM_W'(1)))
		else $error("stripe total below two");

	// Whole-message pieces carry no stripe numbering
	a_plain_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_stripe |-> (stripe_index == '0) && (stripe_total == '0))
		else $error("stripe fields set on a plain piece");

	// The last stripe closes the message
	a_stripe_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_stripe |->
			(last == ({1'b0, stripe_index} == stripe_total - NUM_W'(1))))
		else $error("last flag does not match final stripe");

endmodule
